// ----- rtl/core/acpk_pkg.sv -----
// acpk_pkg: shared types and constants of the uncompressed frame packer
package acpk_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 3;
  localparam int unsigned JOB_BYTES   = 5;
  localparam int unsigned JOB_CNT_W   = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_CODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SWAP_BYTES   = 2'd1;

  localparam logic [2:0] CHANNEL_CODE_RESET = 3'd1;
  localparam logic       SWAP_BYTES_RESET   = 1'b1;

  localparam logic [6:0] PEND_MASK       = 7'h7F;
  localparam int unsigned HDR_ZERO_BITS  = 19;
  localparam logic [2:0] HDR_BYTES       = 3'd4;
  localparam logic [2:0] DATA_BYTES      = 3'd2;
  localparam logic [2:0] HDR_LEFT_BITS   = 3'd7;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       frame_start;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_CNT_W-1:0]      count;
    logic                      last;
  } job_t;

endpackage

// ----- rtl/core/alac_uncompressed_frame_packer.sv -----
// alac_uncompressed_frame_packer: top level of the uncompressed frame bit packer
// the first byte of an accepted sample request passes through the job queue, then the result queue, to result
// throughput: one byte per cycle while the result queue has room, 2-3 bytes per data sample, 4-5 with a frame header
// the byte-wide result queue sets the rate, the job queue lets intake run ahead
// reset: queues emptied, held bits cleared, channel_code 1, swap_bytes 1
module alac_uncompressed_frame_packer import acpk_pkg::*; #(
  parameter int unsigned JOB_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  in_item_t               item,
  output logic                   full,
  input  logic                   pop,
  output out_item_t              result,
  output logic                   empty,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic      accept;
  job_t      job_in;
  job_t      job_head;
  logic      job_full;
  logic      job_empty;
  logic      job_pop;
  out_item_t back_result;
  logic      back_push;
  logic      out_full;

  assign cfg_ready = 1'b1;
  assign full      = job_full;
  assign accept    = push && !job_full;

  acpk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .job       (job_in)
  );

  acpk_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_head),
    .empty (job_empty)
  );

  acpk_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (job_head),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .result      (back_result),
    .result_push (back_push),
    .result_full (out_full)
  );

  acpk_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .wdata (back_result),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

  a_job_count_range: assert property (@(posedge clk) disable iff (rst)
    !job_empty |-> (job_head.count >= 3'd2 && job_head.count <= 3'd5))
    else $error("job byte count out of range");

  a_pop_needs_push: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> back_push)
    else $error("job retired without emitting its final byte");

  a_last_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (back_push && back_result.last_byte) |-> job_pop)
    else $error("last byte flagged before the end of its job");

  a_back_stalls_on_full: assert property (@(posedge clk) disable iff (rst)
    (out_full && !job_empty) |=> ($stable(job_head) || $past(pop)))
    else $error("job advanced while result queue was full");

endmodule

// ----- rtl/core/acpk_fifo.sv -----
// acpk_fifo: small register queue with push/full and pop/empty
module acpk_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/acpk_front.sv -----
// acpk_front: config registers, held bits and per-sample byte job builder
module acpk_front import acpk_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   accept,
  input  in_item_t               item,
  output job_t                   job
);

  logic [2:0]  channel_code;
  logic        swap_bytes;
  logic [6:0]  pending_bits;
  logic [2:0]  pending_count;
  logic [6:0]  pending_bits_next;
  logic [2:0]  pending_count_next;

  logic [15:0] sample;
  logic [22:0] header;
  logic [22:0] held_stream;
  logic [39:0] window;
  logic [2:0]  left_bits;
  logic [2:0]  full_bytes;

  always_comb begin
    sample      = swap_bytes ? {item.second_byte, item.first_byte}
                             : {item.first_byte, item.second_byte};
    header      = {channel_code, {HDR_ZERO_BITS{1'b0}}, 1'b1};
    held_stream = {pending_bits, sample} << (3'd7 - pending_count);
    if (item.frame_start) begin
      window     = {header, sample, 1'b0};
      full_bytes = HDR_BYTES;
      left_bits  = HDR_LEFT_BITS;
    end else begin
      window     = {held_stream, 17'b0};
      full_bytes = DATA_BYTES;
      left_bits  = pending_count;
    end
    for (int i = 0; i < JOB_BYTES; i++) begin
      job.bytes[i] = window[39 - 8*i -: 8];
    end
    job.count = full_bytes + JOB_CNT_W'(item.frame_end && (left_bits != '0));
    job.last  = item.frame_end;
    if (item.frame_end) begin
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      pending_bits_next  = sample[6:0] & ~(PEND_MASK << left_bits);
      pending_count_next = left_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_code  <= CHANNEL_CODE_RESET;
      swap_bytes    <= SWAP_BYTES_RESET;
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CHANNEL_CODE: channel_code <= cfg_data;
          REG_SWAP_BYTES:   swap_bytes   <= cfg_data[0];
          default:          ;
        endcase
      end
      if (accept) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
      end
    end
  end

endmodule

// ----- rtl/core/acpk_back.sv -----
// acpk_back: walks the head job one byte per cycle into the result queue while the result queue has room
module acpk_back import acpk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      job,
  input  logic      job_empty,
  output logic      job_pop,
  output out_item_t result,
  output logic      result_push,
  input  logic      result_full
);

  logic [JOB_CNT_W-1:0] idx;
  logic                 at_end;

  assign at_end           = (idx == job.count - 1'b1);
  assign result_push      = !job_empty && !result_full;
  assign job_pop          = result_push && at_end;
  assign result.out_byte  = job.bytes[idx];
  assign result.last_byte = job.last && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (result_push) begin
      idx <= at_end ? '0 : idx + 1'b1;
    end
  end

endmodule

// ----- verif/acpk_tb_pkg.sv -----
// acpk_tb_pkg: byte tracker class that predicts and checks the packed frame bytes
package acpk_tb_pkg;
  import acpk_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

  class frame_byte_tracker;
    logic [2:0] channel_code;
    logic       swap_bytes;
    logic [6:0] held_bits;
    logic [2:0] held_count;
    out_item_t  packed_bytes[$];
    int unsigned mismatches;

    function new();
      channel_code = CHANNEL_CODE_RESET;
      swap_bytes   = SWAP_BYTES_RESET;
      held_bits    = '0;
      held_count   = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CHANNEL_CODE: channel_code = data[2:0];
        REG_SWAP_BYTES:   swap_bytes = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return packed_bytes.size();
    endfunction

    function void note_sample(in_item_t it);
      logic [63:0] bits;
      logic [15:0] sample;
      int unsigned n;
      int unsigned cnt;
      out_item_t   step_bytes[JOB_BYTES];
      bits = 64'(held_bits);
      n = held_count;
      cnt = 0;
      if (it.frame_start) begin
        bits = 64'({channel_code, 19'd0, 1'b1});
        n = 23;
      end
      sample = swap_bytes ? {it.second_byte, it.first_byte} : {it.first_byte, it.second_byte};
      bits = (bits << 16) | 64'(sample);
      n = n + 16;
      while (n >= 8) begin
        n = n - 8;
        step_bytes[cnt].out_byte = 8'(bits >> n);
        step_bytes[cnt].last_byte = 1'b0;
        cnt++;
      end
      bits = bits & ((64'd1 << n) - 64'd1);
      if (it.frame_end) begin
        if (n > 0) begin
          step_bytes[cnt].out_byte = 8'(bits << (8 - n));
          step_bytes[cnt].last_byte = 1'b0;
          cnt++;
        end
        step_bytes[cnt-1].last_byte = 1'b1;
        bits = '0;
        n = 0;
      end
      held_bits = 7'(bits);
      held_count = 3'(n);
      for (int k = 0; k < cnt; k++) packed_bytes.push_back(step_bytes[k]);
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      if (packed_bytes.size() == 0) begin
        $error("unexpected byte %0h last %0b", got.out_byte, got.last_byte);
        mismatches++;
        return;
      end
      want = packed_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- verif/tb.sv -----
// tb: top level testbench of the uncompressed frame packer
module tb;
  import acpk_pkg::*;
  import acpk_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 50;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  in_item_t               item = '0;
  logic                   full;
  logic                   pop = 1'b0;
  out_item_t              result;
  logic                   empty;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bit idling = 1'b1;
  bit hold_off_req = 1'b0;
  frame_byte_tracker tracker = new();

  alac_uncompressed_frame_packer DUT (
    .clk(clk), .rst(rst),
    .push(push), .item(item), .full(full),
    .pop(pop), .result(result), .empty(empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : receiver
    int unsigned hold = 0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= !(idling && $urandom_range(99) < 14);
      end
      @(posedge clk);
      if (!rst && pop && !empty) tracker.check_byte(result);
      @(negedge clk);
    end
  end

  task automatic send_sample(input in_item_t it);
    while (idling && $urandom_range(99) < 14) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_sample(it);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [2:0] code, input logic [CFG_DATA_W-1:0] swap,
                           input bit poke_unused);
    wait_drained();
    write_reg(REG_CHANNEL_CODE, code);
    write_reg(REG_SWAP_BYTES, swap);
    if (poke_unused) begin
      write_reg(REG_UNUSED_A, 3'($urandom));
      write_reg(REG_UNUSED_B, 3'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned count, input bit with_hold);
    int unsigned sent;
    int unsigned len;
    bit broken;
    in_item_t it;
    sent = 0;
    if (with_hold) hold_off_req = 1'b1;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        it = in_item_t'(18'($urandom));
        send_sample(it);
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(5);
        broken = ($urandom_range(9) == 0);
        for (int k = 0; k <= len; k++) begin
          it.first_byte = 8'($urandom);
          it.second_byte = 8'($urandom);
          it.frame_start = (k == 0);
          it.frame_end = (k == len) && !broken;
          send_sample(it);
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // data with no start, then end with nothing held
    send_sample(in_item_t'{8'hFF, 8'h00, 1'b0, 1'b0});
    send_sample(in_item_t'{8'h00, 8'hFF, 1'b0, 1'b1});
    send_sample(in_item_t'{8'h12, 8'h34, 1'b1, 1'b0});
    send_sample(in_item_t'{8'hFF, 8'hFF, 1'b0, 1'b0});
    send_sample(in_item_t'{8'h00, 8'h00, 1'b0, 1'b1});
    send_sample(in_item_t'{8'hA5, 8'h5A, 1'b1, 1'b1});
    // restart in the middle of a frame drops held bits
    send_sample(in_item_t'{8'h80, 8'h01, 1'b1, 1'b0});
    send_sample(in_item_t'{8'h7F, 8'hFE, 1'b1, 1'b0});
    send_sample(in_item_t'{8'h55, 8'hAA, 1'b0, 1'b1});

    configure(3'd0, 3'd0, 1'b1);
    send_sample(in_item_t'{8'hFF, 8'h00, 1'b1, 1'b1});
    send_sample(in_item_t'{8'h01, 8'h80, 1'b1, 1'b0});
    send_sample(in_item_t'{8'hFF, 8'hFF, 1'b0, 1'b1});

    for (int c = 2; c < 8; c++) begin
      configure(3'(c), 3'(c), 1'b0);
      send_sample(in_item_t'{8'(c * 37), 8'(~c), 1'b1, 1'b1});
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(3'd7, 3'd1, 1'b0);
        1: configure(3'd0, 3'd0, 1'b0);
        default: configure(3'($urandom_range(7)), 3'($urandom), 1'b0);
      endcase
      idling = (p != 1);
      run_phase(PHASE_ITEMS, p == 3);
    end
    idling = 1'b1;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
